@@ rtl/xxhash32_message_hash_defines.svh @@
// ----------------------------------------------------------------------------
// xxHash32 assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef XXHASH32_MESSAGE_HASH_DEFINES_SVH
`define XXHASH32_MESSAGE_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define XXH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define XXH_ASSERT_IMPL(lbl, ante, cons, msg)
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/xxh32_pkg.sv @@
// ----------------------------------------------------------------------------
// xxHash32 package
// Primes, request and status types and the rotate helper.
// ----------------------------------------------------------------------------
package xxh32_pkg;

	localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
	localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
	localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
	localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
	localparam logic [31:0] PRIME5 = 32'h1656_67B1;

	localparam logic [2:0] FULL_WORD = 3'd4;

	// one input request
	typedef struct packed {
		logic        last_word;
		logic [2:0]  byte_count;
		logic [31:0] data_word;
	} item_t;

	// core status seen by the top level
	typedef struct packed {
		logic       idle;
		logic [1:0] fill;
	} status_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

@@ rtl/xxhash32_message_hash.sv @@
// ----------------------------------------------------------------------------
// xxHash32 message hash
// Stream-in words, stream-out one 32-bit hash per message.
// ----------------------------------------------------------------------------
// Words enter on the slave stream; a middle word that does not complete a
// 16-byte stripe is only stored in the stripe buffer. A word that completes
// a stripe runs four lane rounds (RMUL1, RADD, RMUL2, RWB) on the single
// shared multiplier; no new word is taken until the block is idle again.
// The last word then seeds the hash (MINIT), merges the lanes (MERGE) if any
// stripe completed, runs a word round per leftover whole word and a byte
// round per leftover byte, then the avalanche and hand-off. The hash waits
// in an output register, so the next message may start while it is unread.
// The seed register is written on the cfg channel, which is always ready;
// the lanes take it when the first stripe of a message completes, and a
// message with no full stripe takes it when MINIT seeds the hash.
module xxhash32_message_hash import xxh32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
	input  logic        s_axis_tlast,   // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

`include "xxhash32_message_hash_defines.svh"

	logic [31:0] seed_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_busy;
	logic        res_valid;
	logic [31:0] res_hash;
	item_t       item;
	status_t     status;
	logic        in_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= 32'd0;
		else if (cfg_valid && cfg_ready)
			seed_q <= cfg_data;
	end

	assign item.data_word  = s_axis_tdata[31:0];
	assign item.byte_count = s_axis_tdata[34:32];
	assign item.last_word  = s_axis_tlast;

	assign s_axis_tready = status.idle;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_busy      = out_valid_q && !m_axis_tready;

	xxh32_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.in_valid  (s_axis_tvalid),
		.in_item   (item),
		.out_busy  (out_busy),
		.res_valid (res_valid),
		.res_hash  (res_hash),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_data_q <= res_hash;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a finished hash must never overwrite one still waiting
	`XXH_ASSERT_IMPL(a_no_overwrite, res_valid, !out_busy, "hash issued into a full output register")
	// the last word always starts the finishing sequence
	`XXH_ASSERT_NEXT(a_last_busy, in_accept && s_axis_tlast, !s_axis_tready, "ready after last word")
	// a stripe-completing word always runs the lane rounds
	`XXH_ASSERT_NEXT(a_stripe_busy, in_accept && !s_axis_tlast && status.fill == 2'd3,
		!s_axis_tready, "ready after stripe completion")

endmodule

@@ rtl/xxh32_mul.sv @@
// ----------------------------------------------------------------------------
// xxHash32 shared multiplier
// 32x32 multiply keeping the low word, result registered.
// ----------------------------------------------------------------------------
module xxh32_mul import xxh32_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p_q
);

	logic [63:0] prod;

	assign prod = {32'd0, a} * {32'd0, b};

	always_ff @(posedge clk) begin
		p_q <= prod[31:0];
	end

endmodule

@@ rtl/xxh32_core.sv @@
// ----------------------------------------------------------------------------
// xxHash32 sequencer and datapath
// Stripe buffer, lane accumulators and the round/merge/avalanche sequencer
// around one shared multiplier.
// ----------------------------------------------------------------------------
module xxh32_core import xxh32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  logic        in_valid,
	input  item_t       in_item,
	input  logic        out_busy,
	output logic        res_valid,
	output logic [31:0] res_hash,
	output status_t     status
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_RMUL1 = 12'b0000_0000_0010,
		ST_RADD  = 12'b0000_0000_0100,
		ST_RMUL2 = 12'b0000_0000_1000,
		ST_RWB   = 12'b0000_0001_0000,
		ST_MINIT = 12'b0000_0010_0000,
		ST_MERGE = 12'b0000_0100_0000,
		ST_AMUL1 = 12'b0000_1000_0000,
		ST_AX13  = 12'b0001_0000_0000,
		ST_AMUL2 = 12'b0010_0000_0000,
		ST_AFIN  = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		K_LANE = 2'd0,
		K_WORD = 2'd1,
		K_BYTE = 2'd2
	} kind_t;

	state_t      state_q, state_d;
	kind_t       kind_q, kind_d;
	logic [1:0]  idx_q, idx_d;
	logic [1:0]  fill_q;
	logic [1:0]  tword_q;
	logic [1:0]  nbytes_q;
	logic        seen_q;
	logic        last_q;
	logic [31:0] total_q;

	logic [31:0] lane_q [4];
	logic [31:0] sw_q [4];
	logic [31:0] word_q;
	logic [31:0] h_q;
	logic [31:0] t_q;

	logic [31:0] mul_a, mul_b, p_q;
	logic        accept;
	logic [2:0]  eff;
	logic        stripe_full;
	logic [31:0] src_val, base_val, sum_val, rot_val, merge_rot, byte_val;
	logic [2:0]  idx_inc;

	xxh32_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign accept      = (state_q == ST_IDLE) && in_valid;
	assign eff         = !in_item.last_word ? FULL_WORD :
		(in_item.byte_count > FULL_WORD ? FULL_WORD : in_item.byte_count);
	assign stripe_full = (eff == FULL_WORD) && (fill_q == 2'd3);
	assign idx_inc     = {1'b0, idx_q} + 3'd1;

	assign status.idle = (state_q == ST_IDLE);
	assign status.fill = fill_q;

	always_comb begin
		case (idx_q)
			2'd0:    byte_val = {24'd0, word_q[7:0]};
			2'd1:    byte_val = {24'd0, word_q[15:8]};
			2'd2:    byte_val = {24'd0, word_q[23:16]};
			default: byte_val = {24'd0, word_q[31:24]};
		endcase
	end

	assign src_val  = (kind_q == K_BYTE) ? byte_val : sw_q[idx_q];
	assign base_val = (kind_q == K_LANE) ? lane_q[idx_q] : h_q;
	assign sum_val  = base_val + p_q;

	always_comb begin
		case (kind_q)
			K_LANE:  rot_val = rotl(sum_val, 5'd13);
			K_WORD:  rot_val = rotl(sum_val, 5'd17);
			default: rot_val = rotl(sum_val, 5'd11);
		endcase
	end

	always_comb begin
		case (idx_q)
			2'd0:    merge_rot = rotl(lane_q[0], 5'd1);
			2'd1:    merge_rot = rotl(lane_q[1], 5'd7);
			2'd2:    merge_rot = rotl(lane_q[2], 5'd12);
			default: merge_rot = rotl(lane_q[3], 5'd18);
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = t_q;
		mul_b = PRIME1;
		case (state_q)
			ST_RMUL1: begin
				mul_a = src_val;
				case (kind_q)
					K_LANE:  mul_b = PRIME2;
					K_WORD:  mul_b = PRIME3;
					default: mul_b = PRIME5;
				endcase
			end
			ST_RMUL2: begin
				mul_a = t_q;
				mul_b = (kind_q == K_WORD) ? PRIME4 : PRIME1;
			end
			ST_AMUL1: begin
				mul_a = h_q ^ (h_q >> 15);
				mul_b = PRIME2;
			end
			ST_AMUL2: begin
				mul_a = h_q;
				mul_b = PRIME3;
			end
			default: begin
				mul_a = t_q;
				mul_b = PRIME1;
			end
		endcase
	end

	// next state; tail start picks merge, word rounds, byte rounds or avalanche
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (stripe_full) begin
						state_d = ST_RMUL1;
						kind_d  = K_LANE;
						idx_d   = 2'd0;
					end else if (in_item.last_word) begin
						state_d = ST_MINIT;
					end
				end
			end
			ST_RMUL1: state_d = ST_RADD;
			ST_RADD:  state_d = ST_RMUL2;
			ST_RMUL2: state_d = ST_RWB;
			ST_RWB: begin
				case (kind_q)
					K_LANE: begin
						if (idx_q == 2'd3)
							state_d = last_q ? ST_MINIT : ST_IDLE;
						else begin
							idx_d   = idx_inc[1:0];
							state_d = ST_RMUL1;
						end
					end
					K_WORD: begin
						if (idx_inc == {1'b0, tword_q}) begin
							idx_d = 2'd0;
							if (nbytes_q != 2'd0) begin
								kind_d  = K_BYTE;
								state_d = ST_RMUL1;
							end else
								state_d = ST_AMUL1;
						end else begin
							idx_d   = idx_inc[1:0];
							state_d = ST_RMUL1;
						end
					end
					default: begin
						if (idx_inc == {1'b0, nbytes_q})
							state_d = ST_AMUL1;
						else begin
							idx_d   = idx_inc[1:0];
							state_d = ST_RMUL1;
						end
					end
				endcase
			end
			ST_MINIT: begin
				idx_d = 2'd0;
				if (seen_q)
					state_d = ST_MERGE;
				else if (tword_q != 2'd0) begin
					kind_d  = K_WORD;
					state_d = ST_RMUL1;
				end else if (nbytes_q != 2'd0) begin
					kind_d  = K_BYTE;
					state_d = ST_RMUL1;
				end else
					state_d = ST_AMUL1;
			end
			ST_MERGE: begin
				if (idx_q == 2'd3) begin
					idx_d = 2'd0;
					if (tword_q != 2'd0) begin
						kind_d  = K_WORD;
						state_d = ST_RMUL1;
					end else if (nbytes_q != 2'd0) begin
						kind_d  = K_BYTE;
						state_d = ST_RMUL1;
					end else
						state_d = ST_AMUL1;
				end else
					idx_d = idx_inc[1:0];
			end
			ST_AMUL1: state_d = ST_AX13;
			ST_AX13:  state_d = ST_AMUL2;
			ST_AMUL2: state_d = ST_AFIN;
			ST_AFIN:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_valid = (state_q == ST_DONE) && !out_busy;
	assign res_hash  = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= K_LANE;
			idx_q    <= 2'd0;
			fill_q   <= 2'd0;
			tword_q  <= 2'd0;
			nbytes_q <= 2'd0;
			seen_q   <= 1'b0;
			last_q   <= 1'b0;
			total_q  <= 32'd0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			idx_q   <= idx_d;
			if (accept) begin
				total_q <= total_q + {29'd0, eff};
				last_q  <= in_item.last_word;
				if (stripe_full) begin
					seen_q   <= 1'b1;
					fill_q   <= 2'd0;
					tword_q  <= 2'd0;
					nbytes_q <= 2'd0;
				end else if (!in_item.last_word) begin
					fill_q <= fill_q + 2'd1;
				end else if (eff == FULL_WORD) begin
					tword_q  <= fill_q + 2'd1;
					nbytes_q <= 2'd0;
				end else begin
					tword_q  <= fill_q;
					nbytes_q <= eff[1:0];
				end
			end
			if (res_valid) begin
				fill_q  <= 2'd0;
				seen_q  <= 1'b0;
				total_q <= 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= in_item.data_word;
			if (stripe_full) begin
				sw_q[3] <= in_item.data_word;
				if (!seen_q) begin
					lane_q[0] <= seed + PRIME1 + PRIME2;
					lane_q[1] <= seed + PRIME2;
					lane_q[2] <= seed;
					lane_q[3] <= seed - PRIME1;
				end
			end else if (!in_item.last_word || eff == FULL_WORD) begin
				sw_q[fill_q] <= in_item.data_word;
			end
		end
		case (state_q)
			ST_RADD: t_q <= rot_val;
			ST_RWB: begin
				if (kind_q == K_LANE)
					lane_q[idx_q] <= p_q;
				else
					h_q <= p_q;
			end
			ST_MINIT: h_q <= total_q + (seen_q ? 32'd0 : seed + PRIME5);
			ST_MERGE: h_q <= h_q + merge_rot;
			ST_AX13:  h_q <= p_q ^ (p_q >> 13);
			ST_AFIN:  h_q <= p_q ^ (p_q >> 16);
			default: ;
		endcase
	end

endmodule

@@ tb/xxhash32_message_hash_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxHash32 message hash checker
// Watches the seed channel and both streams, computes the hash of each
// message as its words are accepted, and compares every hash leaving the
// block with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module xxhash32_message_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count
	input  logic        s_axis_tlast,   // last_word
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [31:0] hash_value
	output int          hash_errors,
	output int          hashes_pending
);

	localparam logic [31:0] P1 = 32'h9E37_79B1;
	localparam logic [31:0] P2 = 32'h85EB_CA77;
	localparam logic [31:0] P3 = 32'hC2B2_AE3D;
	localparam logic [31:0] P4 = 32'h27D4_EB2F;
	localparam logic [31:0] P5 = 32'h1656_67B1;
	localparam logic [2:0]  WORD_BYTES = 3'd4;

	logic [31:0] seed;
	logic [31:0] lane [4];
	logic [31:0] stripe [4];
	logic [1:0]  fill;
	logic        stripe_done;
	logic [31:0] byte_sum;
	logic [31:0] hash_expected;
	logic [31:0] hash_queue [$];

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] lane_mix(input logic [31:0] acc, input logic [31:0] w);
		logic [31:0] t;
		t = acc + w * P2;
		t = rotl32(t, 13);
		return t * P1;
	endfunction

	task automatic fold_stripe();
		int i;
		// lanes are loaded from the seed by the first full stripe of a message
		if (!stripe_done) begin
			lane[0] = seed + P1 + P2;
			lane[1] = seed + P2;
			lane[2] = seed;
			lane[3] = seed - P1;
			stripe_done = 1'b1;
		end
		for (i = 0; i < 4; i++)
			lane[i] = lane_mix(lane[i], stripe[i]);
	endtask

	task automatic absorb_word(input logic [31:0] w, input logic [2:0] count, input logic last);
		logic [2:0]  eff;
		logic [2:0]  tail;
		logic [31:0] h;
		logic [31:0] b;
		int          i;
		// short counts only matter on the last word; oversize counts saturate
		if (!last)
			eff = WORD_BYTES;
		else
			eff = (count > WORD_BYTES) ? WORD_BYTES : count;
		byte_sum = byte_sum + {29'd0, eff};
		tail = 3'd0;
		if (eff == WORD_BYTES && fill == 2'd3) begin
			stripe[3] = w;
			fold_stripe();
			fill = 2'd0;
		end else if (!last) begin
			stripe[fill] = w;
			fill = fill + 2'd1;
			return;
		end else begin
			tail = eff;
		end
		if (!last)
			return;

		if (stripe_done)
			h = rotl32(lane[0], 1) + rotl32(lane[1], 7) + rotl32(lane[2], 12) +
				rotl32(lane[3], 18);
		else
			h = seed + P5;
		h = h + byte_sum;
		for (i = 0; i < fill; i++) begin
			h = h + stripe[i] * P3;
			h = rotl32(h, 17) * P4;
		end
		if (tail == WORD_BYTES) begin
			h = h + w * P3;
			h = rotl32(h, 17) * P4;
		end else begin
			for (i = 0; i < tail; i++) begin
				b = {24'd0, w[8*i +: 8]};
				h = h + b * P5;
				h = rotl32(h, 11) * P1;
			end
		end
		h = h ^ (h >> 15);
		h = h * P2;
		h = h ^ (h >> 13);
		h = h * P3;
		h = h ^ (h >> 16);

		fill = 2'd0;
		stripe_done = 1'b0;
		byte_sum = '0;
		hash_queue.push_back(h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed = '0;
			for (int i = 0; i < 4; i++) begin
				lane[i] = '0;
				stripe[i] = '0;
			end
			fill = 2'd0;
			stripe_done = 1'b0;
			byte_sum = '0;
			hash_queue.delete();
			hash_errors = 0;
			hashes_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				seed = cfg_data;
			// retire the hash first: it can only belong to an earlier message
			if (m_axis_tvalid && m_axis_tready) begin
				if (hash_queue.size() == 0) begin
					hash_errors++;
					if (hash_errors <= 10)
						$display("%0t: unexpected hash %08h", $realtime, m_axis_tdata);
				end else begin
					hash_expected = hash_queue.pop_front();
					if (m_axis_tdata !== hash_expected) begin
						hash_errors++;
						if (hash_errors <= 10)
							$display("%0t: hash_value expected %08h actual %08h",
								$realtime, hash_expected, m_axis_tdata);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
			hashes_pending = hash_queue.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxHash32 message hash testbench
// Directed edge messages, then random messages under changing seeds and
// back-pressure, including a long output stall. Checking is done by the
// checker module beside the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SEGMENT_WORDS = 80;
	localparam int DRAIN_CYCLES  = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	int   hash_errors;
	int   hashes_pending;
	int   words_sent = 0;
	int   send_gap_pct = 0;
	int   take_gap_pct = 0;
	logic hold_req = 1'b0;

	always #5 clk = ~clk;

	xxhash32_message_hash dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	xxhash32_message_hash_checker u_hash_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.hash_errors    (hash_errors),
		.hashes_pending (hashes_pending)
	);

	// hash receiver; a hold request parks tready low for a long stretch
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** xxhash32_message_hash: FAILED **");
		$finish;
	end

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// called and returns at a falling edge
	task automatic send_word(input logic [31:0] w, input logic [2:0] count, input logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, count, w};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_message();
		int   n;
		int   r;
		int   i;
		logic [2:0] count;
		r = $urandom_range(99);
		if (r < 10)
			n = 0;
		else if (r < 88)
			n = $urandom_range(1, 12);
		else
			n = $urandom_range(13, 40);
		for (i = 0; i < n; i++) begin
			count = 3'd4;
			if ($urandom_range(99) < 8)
				count = 3'($urandom_range(7));
			send_word(pick_word(), count, 1'b0);
		end
		count = 3'($urandom_range(1, 4));
		if ($urandom_range(99) < 12)
			count = 3'($urandom_range(7));
		send_word(pick_word(), count, 1'b1);
	endtask

	// wait for every outstanding hash, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (hashes_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] seeds [6];
		int seg;
		int target;
		int i;
		seeds = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom, 32'h8000_0000, $urandom};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		send_gap_pct = 20;
		take_gap_pct = 20;
		write_seed(32'h0000_0000);
		// empty message, then single-word messages of every length
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
		send_word(32'h0000_0000, 3'd2, 1'b1);
		send_word(32'hA5A5_A5A5, 3'd3, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_word(32'h1234_5678, 3'd7, 1'b1);
		// stripe completed by the last word
		for (i = 0; i < 3; i++)
			send_word(pick_word(), 3'd4, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		// short counts on middle words are ignored; oversize last count
		send_word(32'hDEAD_BEEF, 3'd1, 1'b0);
		send_word(32'h0000_0000, 3'd2, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd3, 1'b0);
		send_word(32'h0102_0304, 3'd0, 1'b0);
		send_word(32'hCAFE_F00D, 3'd5, 1'b1);
		// stripe, three leftover words, last word carrying no bytes
		for (i = 0; i < 7; i++)
			send_word(pick_word(), 3'd4, 1'b0);
		send_word(pick_word(), 3'd0, 1'b1);

		for (seg = 0; seg < 6; seg++) begin
			drain();
			send_gap_pct = (seg < 2) ? 8 : (seg < 4) ? 86 : 0;
			take_gap_pct = (seg < 2) ? 86 : (seg < 4) ? 8 : 0;
			write_seed(seeds[seg]);
			if (seg == 4)
				hold_req = 1'b1;
			target = words_sent + SEGMENT_WORDS;
			while (words_sent < target)
				send_message();
		end
		drain();

		if (hash_errors == 0 && hashes_pending == 0)
			$display("** xxhash32_message_hash: PASSED **");
		else
			$display("** xxhash32_message_hash: FAILED **");
		$finish;
	end

endmodule
